// ===== hdl/fdwd_pkg.sv =====
`timescale 1ns / 1ps

package fdwd_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DELAY_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_REGEN         = 2'd1;
    localparam logic [1:0] CFG_WET_LEVEL     = 2'd2;

    localparam int CFG_DATA_BITS = 16;
    localparam int FRAC_BITS     = 15;

    // Width of a stored and an output sample.
    localparam int SAMPLE_BITS   = 16;

    // Reset values of the configuration registers.
    localparam logic [15:0] DELAY_LENGTH_RESET  = 16'd22050;
    localparam logic [14:0] REGEN_RESET         = 15'd3277;
    localparam logic [15:0] WET_LEVEL_RESET     = 16'd16384;

    // Unity in Q1.15.
    localparam logic [16:0] WET_ONE = 17'd32768;

    typedef struct packed {
        logic signed [15:0] dry_sample;
        logic signed [15:0] mod_gain;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_sample;
        logic               clipped;
    } out_item_t;

endpackage

// ===== hdl/feedback_delay_wet_dry.sv =====
`timescale 1ns / 1ps

// Feedback comb delay with a wet/dry mix.
//
// Input channel (item_valid, item_stall, item): each item carries a dry
// sample and a Q5.10 modulation gain. Output channel (result_valid,
// result_stall, result): one result item per input item, in order, with the
// mixed sample and a flag that is set when the stored or the output value
// saturated. Configuration (cfg_we, cfg_index, cfg_data) writes the delay
// length, feedback gain and wet level; write it only while the block is idle.
// Writing the delay length moves the write position back to entry zero.
//
// The delay memory is read at the edge that accepts an item, together with
// the input register; when the item leaves the middle stage, the multiply,
// round and saturate logic fills the result register and writes the memory.
// One item is taken per cycle while the output does not stall, a rate set by
// the single read and write ports of the delay memory. An output stall holds
// the result register, then the middle stage, and only then raises item_stall.
// Reset loads the configuration reset values and clears all control state;
// the memory reads as zero until each entry is first written (fill count).
module feedback_delay_wet_dry
    import fdwd_pkg::*;
#(
    parameter int DELAY_DEPTH = 32768
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  in_item_t                 item,
    output logic                     result_valid,
    input  logic                     result_stall,
    output out_item_t                result,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int IDX_W = $clog2(DELAY_DEPTH);
    localparam int LEN_W = (IDX_W + 1 > 16) ? IDX_W + 1 : 16;

    // Configuration registers.
    logic [15:0] delay_length_reg;
    logic [15:0] delay_length_next;
    logic [14:0] regen_reg;
    logic [14:0] regen_next;
    logic [15:0] wet_level_reg;
    logic [15:0] wet_level_next;

    // Write position.
    logic [IDX_W-1:0] write_index_reg;
    logic [IDX_W-1:0] write_index_next;
    logic [LEN_W-1:0] len_use;
    logic [IDX_W-1:0] idx_use;
    logic [IDX_W-1:0] idx_inc;

    // Pipeline control.
    logic accept;
    logic out_free;
    logic s1_adv;
    logic s1_valid_reg;
    logic s1_valid_next;
    logic result_valid_reg;
    logic result_valid_next;

    // Pipeline payload.
    in_item_t                      s1_item_reg;
    logic [IDX_W-1:0]              s1_idx_reg;
    logic                          fwd_reg;
    logic signed [SAMPLE_BITS-1:0] fwd_data_reg;
    out_item_t                     result_reg;

    // Datapath.
    logic signed [SAMPLE_BITS-1:0] mem_data;
    logic signed [SAMPLE_BITS-1:0] delayed;
    logic signed [SAMPLE_BITS-1:0] stored;
    out_item_t                     result_calc;

    // ------------------------------------------------------------------
    // Handshake. The middle stage moves on whenever the result register is
    // empty or being emptied; the input is stalled only while the middle
    // stage is full and cannot move.
    // ------------------------------------------------------------------
    assign out_free   = !result_valid_reg || !result_stall;
    assign s1_adv     = s1_valid_reg && out_free;
    assign item_stall = s1_valid_reg && !out_free;
    assign accept     = item_valid && !item_stall;

    assign s1_valid_next     = accept || (s1_valid_reg && !s1_adv);
    assign result_valid_next = s1_adv || (result_valid_reg && result_stall);

    // ------------------------------------------------------------------
    // Length in use and write position. A zero length acts as one and a
    // length beyond the memory acts as its depth. A position at or beyond
    // the length in use falls back to entry zero.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (delay_length_reg == '0)
        begin
            len_use = LEN_W'(1);
        end
        else if (LEN_W'(delay_length_reg) > LEN_W'(DELAY_DEPTH))
        begin
            len_use = LEN_W'(DELAY_DEPTH);
        end
        else
        begin
            len_use = LEN_W'(delay_length_reg);
        end
    end

    assign idx_use = (LEN_W'(write_index_reg) >= len_use) ? '0 : write_index_reg;
    assign idx_inc = (LEN_W'(idx_use) + LEN_W'(1) >= len_use) ? '0 : idx_use + 1'b1;

    // ------------------------------------------------------------------
    // Configuration and write position updates.
    // ------------------------------------------------------------------
    always_comb
    begin
        delay_length_next  = delay_length_reg;
        regen_next         = regen_reg;
        wet_level_next     = wet_level_reg;
        write_index_next   = write_index_reg;
        if (accept)
        begin
            write_index_next = idx_inc;
        end
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DELAY_LENGTH:
                begin
                    delay_length_next = cfg_data;
                    write_index_next  = '0;
                end
                CFG_REGEN:
                begin
                    regen_next = cfg_data[14:0];
                end
                CFG_WET_LEVEL:
                begin
                    wet_level_next = cfg_data;
                end
                default:
                begin
                    // Unknown register indexes are ignored.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_length_reg  <= DELAY_LENGTH_RESET;
            regen_reg         <= REGEN_RESET;
            wet_level_reg     <= WET_LEVEL_RESET;
            write_index_reg   <= '0;
            s1_valid_reg      <= 1'b0;
            result_valid_reg  <= 1'b0;
            fwd_reg           <= 1'b0;
        end
        else
        begin
            delay_length_reg  <= delay_length_next;
            regen_reg         <= regen_next;
            wet_level_reg     <= wet_level_next;
            write_index_reg   <= write_index_next;
            s1_valid_reg      <= s1_valid_next;
            result_valid_reg  <= result_valid_next;
            if (accept)
            begin
                // The item leaving the middle stage writes its entry at this
                // same edge; when it is the entry just read (a length of
                // one), its value is passed along instead of the stale read.
                fwd_reg <= s1_adv && (s1_idx_reg == idx_use);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg  <= item;
            s1_idx_reg   <= idx_use;
            fwd_data_reg <= stored;
        end
        if (s1_adv)
        begin
            result_reg <= result_calc;
        end
    end

    // ------------------------------------------------------------------
    // Delay memory: read at acceptance, written back when the item leaves
    // the middle stage.
    // ------------------------------------------------------------------
    fdwd_store #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (idx_use),
        .rd_data (mem_data),
        .wr_en   (s1_adv),
        .wr_addr (s1_idx_reg),
        .wr_data (stored)
    );

    assign delayed = fwd_reg ? fwd_data_reg : mem_data;

    fdwd_datapath u_datapath (
        .item          (s1_item_reg),
        .delayed       (delayed),
        .regen         (regen_reg),
        .wet_level     (wet_level_reg),
        .stored        (stored),
        .result        (result_calc)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    // An accepted item always lands in the middle stage.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> s1_valid_reg)
        else $error("accepted item lost before the middle stage");

    // An item leaving the middle stage always shows up as a result.
    assert property (@(posedge clk) disable iff (!rst_n) s1_adv |=> result_valid_reg)
        else $error("item left the middle stage without a result");

    // The write position stays inside the length in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        LEN_W'(write_index_reg) < len_use)
        else $error("write position outside the delay length");
`endif

endmodule

// ===== hdl/fdwd_store.sv =====
`timescale 1ns / 1ps

module fdwd_store
    import fdwd_pkg::*;
#(
    parameter int DELAY_DEPTH = 32768
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [$clog2(DELAY_DEPTH)-1:0] rd_addr,
    output logic signed [SAMPLE_BITS-1:0]  rd_data,
    input  logic                           wr_en,
    input  logic [$clog2(DELAY_DEPTH)-1:0] wr_addr,
    input  logic signed [SAMPLE_BITS-1:0]  wr_data
);

    localparam int IDX_W = $clog2(DELAY_DEPTH);

    logic signed [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic                          rd_hit_reg;
    logic                          rd_hit_next;
    logic [IDX_W:0]                fill_reg;
    logic [IDX_W:0]                fill_next;

    // Writes always run upward from entry zero, so the written entries form a
    // prefix of the memory. Entries at or above the fill count read as zero.
    always_comb
    begin
        fill_next   = fill_reg;
        rd_hit_next = rd_hit_reg;
        if (wr_en && ({1'b0, wr_addr} == fill_reg))
        begin
            fill_next = fill_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_hit_next = ({1'b0, rd_addr} < fill_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            rd_hit_reg <= rd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

// ===== hdl/fdwd_datapath.sv =====
`timescale 1ns / 1ps

module fdwd_datapath
    import fdwd_pkg::*;
(
    input  in_item_t                      item,
    input  logic signed [SAMPLE_BITS-1:0] delayed,
    input  logic [14:0]                   regen,
    input  logic [15:0]                   wet_level,
    output logic signed [SAMPLE_BITS-1:0] stored,
    output out_item_t                     result
);

    localparam int ACC_W = (SAMPLE_BITS + 19 > 40) ? SAMPLE_BITS + 19 : 40;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (FRAC_BITS - 1);

    logic [16:0]                   wet;
    logic [16:0]                   dry_share;
    logic signed [31:0]            mod_prod;
    logic signed [SAMPLE_BITS+16:0] fb_prod;
    logic signed [SAMPLE_BITS+17:0] wet_prod;
    logic signed [33:0]            dry_prod;
    logic signed [ACC_W-1:0]       store_acc;
    logic signed [ACC_W-1:0]       mix_acc;
    logic signed [ACC_W-1:0]       store_q;
    logic signed [ACC_W-1:0]       mix_q;
    logic                          store_fits;
    logic                          mix_fits;
    logic signed [SAMPLE_BITS-1:0] mixed;

    // Wet levels above one act as fully wet.
    assign wet       = (wet_level[15] && (|wet_level[14:0])) ? WET_ONE : {1'b0, wet_level};
    assign dry_share = WET_ONE - wet;

    assign mod_prod = item.dry_sample * item.mod_gain;
    assign fb_prod  = $signed({2'b00, regen}) * delayed;
    assign wet_prod = $signed({1'b0, wet}) * delayed;
    assign dry_prod = $signed({1'b0, dry_share}) * item.dry_sample;

    // The Q5.10 gain times 32 lines the modulated sample up with Q0.15.
    assign store_acc = (ACC_W'(mod_prod) <<< 5) + ACC_W'(fb_prod) + RND;
    assign mix_acc   = ACC_W'(wet_prod) + ACC_W'(dry_prod) + RND;

    assign store_q = store_acc >>> FRAC_BITS;
    assign mix_q   = mix_acc >>> FRAC_BITS;

    // A value fits when every bit above the sample's sign bit copies it.
    assign store_fits = (&store_q[ACC_W-1:SAMPLE_BITS-1]) | ~(|store_q[ACC_W-1:SAMPLE_BITS-1]);
    assign mix_fits   = (&mix_q[ACC_W-1:SAMPLE_BITS-1]) | ~(|mix_q[ACC_W-1:SAMPLE_BITS-1]);

    always_comb
    begin
        if (store_fits)
        begin
            stored = store_q[SAMPLE_BITS-1:0];
        end
        else
        begin
            stored = {store_q[ACC_W-1], {(SAMPLE_BITS-1){~store_q[ACC_W-1]}}};
        end
        if (mix_fits)
        begin
            mixed = mix_q[SAMPLE_BITS-1:0];
        end
        else
        begin
            mixed = {mix_q[ACC_W-1], {(SAMPLE_BITS-1){~mix_q[ACC_W-1]}}};
        end
    end

    assign result.out_sample = 16'(mixed);
    assign result.clipped    = ~store_fits | ~mix_fits;

endmodule
